/* design/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  typedef struct packed {
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic nd_sat;
  } ctrl_t;

endpackage

/* design/cau_front.sv */
// ----------------------------------------------------------------------------
// cau_front
// Product stage and sum stage: add, subtract and multiply results, and the
// numerators and squared magnitude for division.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  cau_pkg::action_t    action,
  input  logic signed [W-1:0] a_re,
  input  logic signed [W-1:0] a_im,
  input  logic signed [W-1:0] b_re,
  input  logic signed [W-1:0] b_im,
  output logic                out_valid,
  output cau_pkg::ctrl_t      out_ctrl,
  output logic [2*W-1:0]      mag_re,
  output logic [2*W-1:0]      mag_im,
  output logic [2*W-1:0]      den,
  output logic [W-1:0]        nd_re,
  output logic [W-1:0]        nd_im
);
  import cau_pkg::*;

  logic                  v1;
  action_t               act1;
  logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  logic signed [W:0]     s_re, s_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      act1 <= action;
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
      p_br <= b_re * b_re;
      p_bi <= b_im * b_im;
      if (action == ACT_SUB) begin
        s_re <= (W+1)'(a_re) - (W+1)'(b_re);
        s_im <= (W+1)'(a_im) - (W+1)'(b_im);
      end else begin
        s_re <= (W+1)'(a_re) + (W+1)'(b_re);
        s_im <= (W+1)'(a_im) + (W+1)'(b_im);
      end
    end
  end

  logic signed [2*W:0] m_re, m_im, v_re, v_im, n_re, n_im, den_w;
  logic [2*W:0]        a_nre, a_nim;
  logic                sat_re, sat_im;
  logic [W-1:0]        c_re, c_im;

  always_comb begin
    m_re  = ((2*W+1)'(p_rr) - (2*W+1)'(p_ii)) >>> F;
    m_im  = ((2*W+1)'(p_ri) + (2*W+1)'(p_ir)) >>> F;
    n_re  = (2*W+1)'(p_rr) + (2*W+1)'(p_ii);
    n_im  = (2*W+1)'(p_ir) - (2*W+1)'(p_ri);
    den_w = (2*W+1)'(p_br) + (2*W+1)'(p_bi);
    a_nre = n_re[2*W] ? -n_re : n_re;
    a_nim = n_im[2*W] ? -n_im : n_im;
    if (act1 == ACT_MUL) begin
      v_re = m_re;
      v_im = m_im;
    end else begin
      v_re = (2*W+1)'(s_re);
      v_im = (2*W+1)'(s_im);
    end
    sat_re = !((&v_re[2*W:W-1]) || !(|v_re[2*W:W-1]));
    sat_im = !((&v_im[2*W:W-1]) || !(|v_im[2*W:W-1]));
    c_re = sat_re ? {v_re[2*W], {(W-1){~v_re[2*W]}}} : v_re[W-1:0];
    c_im = sat_im ? {v_im[2*W], {(W-1){~v_im[2*W]}}} : v_im[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_ctrl.is_div <= (act1 == ACT_DIV);
      out_ctrl.dz     <= (act1 == ACT_DIV) && (den_w == '0);
      out_ctrl.neg_re <= n_re[2*W];
      out_ctrl.neg_im <= n_im[2*W];
      out_ctrl.nd_sat <= sat_re || sat_im;
      mag_re <= a_nre[2*W-1:0];
      mag_im <= a_nim[2*W-1:0];
      den    <= den_w[2*W-1:0];
      nd_re  <= c_re;
      nd_im  <= c_im;
    end
  end

endmodule

/* design/cau_div.sv */
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, an overflow check stage and then one quotient bit
// per stage, for the real and imaginary numerators over a shared squared magnitude.
// ----------------------------------------------------------------------------
module cau_div #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  cau_pkg::ctrl_t in_ctrl,
  input  logic [2*W-1:0] mag_re,
  input  logic [2*W-1:0] mag_im,
  input  logic [2*W-1:0] den,
  input  logic [W-1:0]   nd_re,
  input  logic [W-1:0]   nd_im,
  output logic           out_valid,
  output cau_pkg::ctrl_t out_ctrl,
  output logic [W-1:0]   out_nd_re,
  output logic [W-1:0]   out_nd_im,
  output logic [W:0]     q_re,
  output logic [W:0]     q_im,
  output logic           ovf_re,
  output logic           ovf_im
);
  import cau_pkg::*;

  localparam int S = W + 2;
  localparam int R = 3 * W + F + 2;

  logic           v_a     [0:S];
  ctrl_t          c_a     [0:S];
  logic [R-1:0]   rre_a   [0:S];
  logic [R-1:0]   rim_a   [0:S];
  logic [2*W-1:0] den_a   [0:S];
  logic [W-1:0]   ndre_a  [0:S];
  logic [W-1:0]   ndim_a  [0:S];
  logic [W:0]     qre_a   [0:S];
  logic [W:0]     qim_a   [0:S];
  logic           ore_a   [0:S];
  logic           oim_a   [0:S];

  assign v_a[0]    = in_valid;
  assign c_a[0]    = in_ctrl;
  assign rre_a[0]  = R'(mag_re) << F;
  assign rim_a[0]  = R'(mag_im) << F;
  assign den_a[0]  = den;
  assign ndre_a[0] = nd_re;
  assign ndim_a[0] = nd_im;
  assign qre_a[0]  = '0;
  assign qim_a[0]  = '0;
  assign ore_a[0]  = 1'b0;
  assign oim_a[0]  = 1'b0;

  for (genvar j = 0; j < S; j++) begin : g_stage
    localparam int K = W + 1 - j;
    logic [R-1:0]   dsh;
    logic           ge_re, ge_im;
    logic           v_q;
    ctrl_t          c_q;
    logic [R-1:0]   rre_q, rim_q;
    logic [2*W-1:0] den_q;
    logic [W-1:0]   ndre_q, ndim_q;
    logic [W:0]     qre_q, qim_q;
    logic           ore_q, oim_q;

    assign dsh   = R'(den_a[j]) << K;
    assign ge_re = rre_a[j] >= dsh;
    assign ge_im = rim_a[j] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (ce) begin
        v_q <= v_a[j];
      end
    end

    if (j == 0) begin : g_ovf
      always_ff @(posedge clk) begin
        if (ce) begin
          rre_q <= rre_a[j];
          rim_q <= rim_a[j];
          qre_q <= qre_a[j];
          qim_q <= qim_a[j];
          ore_q <= ge_re;
          oim_q <= ge_im;
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (ce) begin
          rre_q <= ge_re ? rre_a[j] - dsh : rre_a[j];
          rim_q <= ge_im ? rim_a[j] - dsh : rim_a[j];
          qre_q <= qre_a[j] | ((W+1)'(ge_re) << K);
          qim_q <= qim_a[j] | ((W+1)'(ge_im) << K);
          ore_q <= ore_a[j];
          oim_q <= oim_a[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        c_q    <= c_a[j];
        den_q  <= den_a[j];
        ndre_q <= ndre_a[j];
        ndim_q <= ndim_a[j];
      end
    end

    assign v_a[j+1]    = v_q;
    assign c_a[j+1]    = c_q;
    assign rre_a[j+1]  = rre_q;
    assign rim_a[j+1]  = rim_q;
    assign den_a[j+1]  = den_q;
    assign ndre_a[j+1] = ndre_q;
    assign ndim_a[j+1] = ndim_q;
    assign qre_a[j+1]  = qre_q;
    assign qim_a[j+1]  = qim_q;
    assign ore_a[j+1]  = ore_q;
    assign oim_a[j+1]  = oim_q;
  end

  assign out_valid = v_a[S];
  assign out_ctrl  = c_a[S];
  assign out_nd_re = ndre_a[S];
  assign out_nd_im = ndim_a[S];
  assign q_re      = qre_a[S];
  assign q_im      = qim_a[S];
  assign ovf_re    = ore_a[S];
  assign ovf_im    = oim_a[S];

endmodule

/* design/complex_arith_unit.sv */
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// The pipeline is a product stage, a sum stage, DATA_WIDTH + 2 divider stages
// and the output register.
// Throughput is one request per cycle; a stall on the output holds every stage.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // a_re, a_im, b_re, b_im
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
  // action
  input  cau_pkg::action_t                       s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // res_re, res_im
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
  // status
  output cau_pkg::status_t                       m_tuser
);
  import cau_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int OUTW = ((2*DATA_WIDTH+7)/8)*8;

  logic           ce;
  logic           f_valid, d_valid;
  ctrl_t          f_ctrl, d_ctrl;
  logic [2*W-1:0] f_mre, f_mim, f_den;
  logic [W-1:0]   f_ndre, f_ndim, d_ndre, d_ndim;
  logic [W:0]     q_re, q_im;
  logic           ovf_re, ovf_im;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  cau_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(s_tvalid), .action(s_tuser),
    .a_re(s_tdata[W-1:0]), .a_im(s_tdata[2*W-1:W]),
    .b_re(s_tdata[3*W-1:2*W]), .b_im(s_tdata[4*W-1:3*W]),
    .out_valid(f_valid), .out_ctrl(f_ctrl), .mag_re(f_mre), .mag_im(f_mim),
    .den(f_den), .nd_re(f_ndre), .nd_im(f_ndim)
  );

  cau_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(f_valid), .in_ctrl(f_ctrl),
    .mag_re(f_mre), .mag_im(f_mim), .den(f_den), .nd_re(f_ndre), .nd_im(f_ndim),
    .out_valid(d_valid), .out_ctrl(d_ctrl), .out_nd_re(d_ndre), .out_nd_im(d_ndim),
    .q_re(q_re), .q_im(q_im), .ovf_re(ovf_re), .ovf_im(ovf_im)
  );

  logic         sr, si;
  logic [W-1:0] dr, di, res_re, res_im;
  status_t      st;

  always_comb begin
    sr = ovf_re || q_re[W] ||
         (d_ctrl.neg_re ? (q_re[W-1] && (|q_re[W-2:0])) : q_re[W-1]);
    si = ovf_im || q_im[W] ||
         (d_ctrl.neg_im ? (q_im[W-1] && (|q_im[W-2:0])) : q_im[W-1]);
    if (sr) begin
      dr = {d_ctrl.neg_re, {(W-1){~d_ctrl.neg_re}}};
    end else begin
      dr = d_ctrl.neg_re ? -q_re[W-1:0] : q_re[W-1:0];
    end
    if (si) begin
      di = {d_ctrl.neg_im, {(W-1){~d_ctrl.neg_im}}};
    end else begin
      di = d_ctrl.neg_im ? -q_im[W-1:0] : q_im[W-1:0];
    end
    if (!d_ctrl.is_div) begin
      res_re = d_ndre;
      res_im = d_ndim;
      st     = d_ctrl.nd_sat ? ST_SAT : ST_OK;
    end else if (d_ctrl.dz) begin
      res_re = '0;
      res_im = '0;
      st     = ST_DZ;
    end else begin
      res_re = dr;
      res_im = di;
      st     = (sr || si) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= OUTW'({res_im, res_re});
      m_tuser <= st;
    end
  end

  a_ready: assert property (@(posedge clk) s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_DZ) |-> (m_tdata == '0))
    else $error("divide by zero result is not zero");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SAT || m_tuser == ST_DZ))
    else $error("invalid status code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (d_valid && !ce) |=> d_valid)
    else $error("pipeline lost an item during a stall");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Streams complex operand pairs with all four actions into the complex
// arithmetic unit under random source gaps and sink stalls. Every result is
// checked field by field against a listed or an in-bench fixed-point result.
// ----------------------------------------------------------------------------
module tb_top;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam longint VMAX = 32767;
  localparam longint VMIN = -32768;

  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    status_t     st;
  } cplx_res_t;

  typedef struct {
    action_t     act;
    logic [15:0] ar, ai, br, bi;
    logic        fixed;
    cplx_res_t   res;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  action_t     s_tuser = ACT_ADD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  status_t     m_tuser;

  cplx_res_t results_due[$];
  bit        failed = 1'b0;
  bit        send_done = 1'b0;
  op_row_t   rows[$];
  int        out_count = 0;
  int        sink_seen = 0;
  int        sink_wait = 0;

  complex_arith_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint clamp16(longint v, ref bit sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  function automatic longint quotient_part(longint num, longint den, ref bit sat);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    if (mag / den > (longint'(1) << (DW - 1 - FB))) begin
      sat = 1'b1;
      return (num < 0) ? VMIN : VMAX;
    end
    q = (mag << FB) / den;
    return clamp16((num < 0) ? -q : q, sat);
  endfunction

  function automatic cplx_res_t complex_result(action_t act, logic [15:0] a_re,
                                               logic [15:0] a_im, logic [15:0] b_re,
                                               logic [15:0] b_im);
    longint ar, ai, br, bi, rr, ri, den;
    bit sat;
    cplx_res_t r;
    ar = longint'($signed(a_re));
    ai = longint'($signed(a_im));
    br = longint'($signed(b_re));
    bi = longint'($signed(b_im));
    rr = 0;
    ri = 0;
    sat = 1'b0;
    r.st = ST_OK;
    case (act)
      ACT_ADD: begin
        rr = clamp16(ar + br, sat);
        ri = clamp16(ai + bi, sat);
      end
      ACT_SUB: begin
        rr = clamp16(ar - br, sat);
        ri = clamp16(ai - bi, sat);
      end
      ACT_MUL: begin
        rr = clamp16((ar * br - ai * bi) >>> FB, sat);
        ri = clamp16((ar * bi + br * ai) >>> FB, sat);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DZ;
        end else begin
          rr = quotient_part(ar * br + ai * bi, den, sat);
          ri = quotient_part(br * ai - ar * bi, den, sat);
        end
      end
    endcase
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    r.re = rr[15:0];
    r.im = ri[15:0];
    return r;
  endfunction

  function automatic op_row_t row(action_t act, logic [15:0] ar, logic [15:0] ai,
                                  logic [15:0] br, logic [15:0] bi, logic fixed = 1'b0,
                                  logic [15:0] rre = '0, logic [15:0] rim = '0,
                                  status_t st = ST_OK);
    op_row_t t;
    t.act = act;
    t.ar = ar;
    t.ai = ai;
    t.br = br;
    t.bi = bi;
    t.fixed = fixed;
    t.res.re = rre;
    t.res.im = rim;
    t.res.st = st;
    return t;
  endfunction

  task automatic send_request(op_row_t t);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= t.act;
    s_tdata <= {t.bi, t.br, t.ai, t.ar};
    if (t.fixed) results_due.push_back(t.res);
    else results_due.push_back(complex_result(t.act, t.ar, t.ai, t.br, t.bi));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      3: return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    op_row_t t;
    rows.push_back(row(ACT_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    rows.push_back(row(ACT_ADD, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 1'b1,
                       16'h7FFF, 16'h8000, ST_SAT));
    rows.push_back(row(ACT_ADD, 16'h0100, 16'h0200, 16'h0300, 16'h0000, 1'b1,
                       16'h0400, 16'h0200, ST_OK));
    rows.push_back(row(ACT_SUB, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 1'b1,
                       16'h8000, 16'h7FFF, ST_SAT));
    rows.push_back(row(ACT_SUB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    rows.push_back(row(ACT_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1,
                       16'h0100, 16'h0000, ST_OK));
    rows.push_back(row(ACT_MUL, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 1'b1,
                       16'hFF00, 16'h0000, ST_OK));
    rows.push_back(row(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    rows.push_back(row(ACT_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
    rows.push_back(row(ACT_MUL, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000));
    rows.push_back(row(ACT_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000, 1'b1,
                       16'h0000, 16'h0000, ST_DZ));
    rows.push_back(row(ACT_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1,
                       16'h0100, 16'h0000, ST_OK));
    rows.push_back(row(ACT_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000));
    rows.push_back(row(ACT_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0001));
    rows.push_back(row(ACT_DIV, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000));
    rows.push_back(row(ACT_DIV, 16'h8000, 16'h0000, 16'h8000, 16'h0000));
    rows.push_back(row(ACT_DIV, 16'h8000, 16'h0000, 16'h0080, 16'h0000));
    rows.push_back(row(ACT_DIV, 16'h0300, 16'hFD00, 16'hFF00, 16'h0100));
    rows.push_back(row(ACT_DIV, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF));
    rows.push_back(row(ACT_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000));
    rows.push_back(row(ACT_DIV, 16'hFF00, 16'h0000, 16'h0300, 16'h0000));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_request(rows[i]);
    repeat (1150) begin
      t = row(action_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand());
      if ($urandom_range(0, 29) == 0) begin
        t.br = '0;
        t.bi = '0;
      end
      send_request(t);
    end
    s_tvalid <= 1'b0;
    send_done = 1'b1;
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_seen = 0;
      sink_wait = $urandom_range(0, 17);
    end else begin
      if (out_count != sink_seen) begin
        sink_seen = out_count;
        sink_wait = $urandom_range(0, 17);
      end
      if (sink_wait > 0) begin
        m_tready <= 1'b0;
        sink_wait = sink_wait - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      out_count = out_count + 1;
      if (results_due.size() == 0) begin
        $error("result with no request pending: tdata %h", m_tdata);
        failed = 1'b1;
      end else begin
        e = results_due.pop_front();
        if (m_tdata[15:0] !== e.re) begin
          $error("res_re expected %h actual %h", e.re, m_tdata[15:0]);
          failed = 1'b1;
        end
        if (m_tdata[31:16] !== e.im) begin
          $error("res_im expected %h actual %h", e.im, m_tdata[31:16]);
          failed = 1'b1;
        end
        if (m_tuser !== e.st) begin
          $error("status expected %0d actual %0d", e.st, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    wait (send_done);
    while (results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!failed) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* sim.f */
design/cau_pkg.sv
design/cau_front.sv
design/cau_div.sv
design/complex_arith_unit.sv
bench/tb_top.sv
